// ===== rtl/core/combination_unrank_top_macros.svh =====
// ----------------------------------------------------------------------------
// Combination unranking: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMBINATION_UNRANK_TOP_MACROS_SVH
`define COMBINATION_UNRANK_TOP_MACROS_SVH

// Same-cycle implication.
`define CU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cu_pkg.sv =====
// ----------------------------------------------------------------------------
// Combination unranking: package
// Widths, register indexes and reset values of the unranking block.
// ----------------------------------------------------------------------------
package cu_pkg;

    localparam int MAX_SET_DEF = 32;

    localparam int RANK_W  = 32;
    localparam int ELEM_W  = 6;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int TABLE_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHOOSE_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] SET_SIZE_RST     = 6'd32;
    localparam logic [CFG_W-1:0] CHOOSE_COUNT_RST = 6'd1;

endpackage

// ===== rtl/core/combination_unrank_top.sv =====
// ----------------------------------------------------------------------------
// Combination unranking: top level
// Turns a lexicographic rank into the k-of-n combination it names, one
// value per output beat, using a binomial table built after reset.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake            | Beat contents
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_stall  | rank
//  output   | out       | out_valid / out_stall| element, last, rank_error
//  config   | in        | cfg_we               | cfg_index, cfg_data
//
//  After reset the block builds the binomial table C(a,b), a,b < MAX_SET, in
//  its table memory, during which in_stall is high. Config writes are taken.
//  The single table read port and one compare-and-subtract unit are visited
//  once per candidate value, plus one table lookup and one output load per
//  chosen value. Only one rank is in work at a time.
//  A stalled output beat holds the sequencer in its output step; a new rank
//  is accepted while the final beat of the previous one still waits.
//
module combination_unrank_top #(
    parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cu_pkg::RANK_W-1:0]     rank,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cu_pkg::ELEM_W-1:0]     element,
    output logic                          last,
    output logic                          rank_error,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cu_pkg::CFG_W-1:0]      cfg_data
);
    import cu_pkg::*;

    // The table is addressed by {a, b}; each half needs just enough bits
    // for MAX_SET - 1.
    localparam int AW    = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int DEPTH = 1 << (2 * AW);
    localparam logic [AW-1:0]    IDX_LAST = AW'(MAX_SET - 1);
    localparam logic [CFG_W-1:0] MAX_N    = CFG_W'(MAX_SET);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COMPARE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   set_size_reg, set_size_next;
    logic [CFG_W-1:0]   choose_count_reg, choose_count_next;

    // Table build sweep.
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      b_reg, b_next;
    logic [TABLE_W-1:0] prev_reg, prev_next;

    // Walk state: remaining rank, current candidate, values still to choose.
    logic [RANK_W-1:0]  r_reg, r_next;
    logic [CFG_W-1:0]   v_reg, v_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic               err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]  element_reg, element_next;
    logic               last_reg, last_next;
    logic               rank_error_reg, rank_error_next;

    // Table memory, one write and one registered read per cycle.
    logic [TABLE_W-1:0] table_mem [0:DEPTH-1];
    logic [TABLE_W-1:0] rd_data_reg;
    logic [2*AW-1:0]    rd_addr;
    logic [2*AW-1:0]    wr_addr;
    logic [TABLE_W-1:0] wr_data;
    logic               wr_en;

    logic               out_free;
    logic               sweep_end;
    logic               bad_cfg;
    logic [CFG_W-1:0]   cand_a;
    logic [CFG_W-1:0]   spec_a;
    logic [CFG_W:0]     reach;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign element    = element_reg;
    assign last       = last_reg;
    assign rank_error = rank_error_reg;

    // The output register can take a new beat if it is empty or is being
    // drained in this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign sweep_end = (a_reg == IDX_LAST) && (b_reg == IDX_LAST);

    // A configuration that names no combination at all gives the error beat.
    assign bad_cfg = (set_size_reg == '0) || (set_size_reg > MAX_N) ||
                     (choose_count_reg == '0) || (choose_count_reg > set_size_reg);

    // Row n - v holds the completions left after picking v; the speculative
    // address is for the candidate after it, so the next compare finds its
    // data ready in the read register.
    assign cand_a = set_size_reg - v_reg;
    assign spec_a = set_size_reg - v_reg - 1'b1;
    assign reach  = {1'b0, v_reg} + {1'b0, rem_reg};

    always_comb
    begin
        state_next        = state_reg;
        set_size_next     = set_size_reg;
        choose_count_next = choose_count_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        prev_next         = prev_reg;
        r_next            = r_reg;
        v_next            = v_reg;
        rem_next          = rem_reg;
        err_next          = err_reg;
        out_valid_next    = out_valid_reg;
        element_next      = element_reg;
        last_next         = last_reg;
        rank_error_next   = rank_error_reg;
        wr_en             = 1'b0;
        wr_addr           = {a_reg, b_reg};
        wr_data           = '0;
        rd_addr           = {AW'(a_reg - 1'b1), b_reg};

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_SIZE:     set_size_next     = cfg_data;
                REG_CHOOSE_COUNT: choose_count_next = cfg_data;
                default:          ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                if ((a_reg == '0) || (b_reg == '0))
                begin
                    // Column zero is all ones, row zero is zero elsewhere.
                    wr_en   = 1'b1;
                    wr_data = (b_reg == '0) ? TABLE_W'(1) : '0;
                    if (b_reg == '0)
                    begin
                        prev_next = TABLE_W'(1);
                    end
                    if (sweep_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (b_reg == IDX_LAST)
                    begin
                        b_next = '0;
                        a_next = a_reg + 1'b1;
                    end
                    else
                    begin
                        b_next = b_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_INIT_WR;
                end
            end

            ST_INIT_WR:
            begin
                // C(a,b) = C(a-1,b) + C(a-1,b-1); the latter is kept from
                // the previous entry of this row.
                wr_en     = 1'b1;
                wr_data   = rd_data_reg + prev_reg;
                prev_next = rd_data_reg;
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_INIT;
                    if (b_reg == IDX_LAST)
                    begin
                        b_next = '0;
                        a_next = a_reg + 1'b1;
                    end
                    else
                    begin
                        b_next = b_reg + 1'b1;
                    end
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    r_next   = rank;
                    v_next   = CFG_W'(1);
                    rem_next = choose_count_reg - 1'b1;
                    if (bad_cfg)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                rd_addr    = {cand_a[AW-1:0], rem_reg[AW-1:0]};
                state_next = ST_COMPARE;
            end

            ST_COMPARE:
            begin
                rd_addr = {spec_a[AW-1:0], rem_reg[AW-1:0]};
                if (reach > {1'b0, set_size_reg})
                begin
                    // Candidates ran out: the rank lies beyond C(n,k). This
                    // can only happen for the first value.
                    err_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (r_reg < rd_data_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    r_next = r_reg - rd_data_reg;
                    v_next = v_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    element_next    = err_reg ? '0 : v_reg;
                    last_next       = err_reg || (rem_reg == '0);
                    rank_error_next = err_reg;
                    if (err_reg || (rem_reg == '0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + 1'b1;
                        rem_next   = rem_reg - 1'b1;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            set_size_reg     <= SET_SIZE_RST;
            choose_count_reg <= CHOOSE_COUNT_RST;
            a_reg            <= '0;
            b_reg            <= '0;
            err_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            set_size_reg     <= set_size_next;
            choose_count_reg <= choose_count_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            err_reg          <= err_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload and walk registers carry no reset.
    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        r_reg          <= r_next;
        v_reg          <= v_next;
        rem_reg        <= rem_next;
        element_reg    <= element_next;
        last_reg       <= last_next;
        rank_error_reg <= rank_error_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

`include "combination_unrank_top_macros.svh"

    `CU_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                   "block accepted a rank but did not go busy")
    `CU_ASSERT_IMP(a_error_beat_form, out_valid && rank_error, (element == '0) && last,
                   "error beat must carry element zero and last")
    `CU_ASSERT_IMP(a_candidate_nonzero, state_reg == ST_COMPARE, v_reg != '0,
                   "candidate value zero reached the compare step")
    `CU_ASSERT_IMP(a_partial_busy, out_valid && !last, state_reg != ST_IDLE,
                   "block went idle before the last beat of a rank")

endmodule

// ===== dv/combination_unrank_top_tb.sv =====
// ----------------------------------------------------------------------------
// Combination unranking: testbench
// Sends ranks under a range of set sizes and choose counts and checks every
// output beat against a local model of lexicographic unranking. The model
// uses its own Pascal table. Both channels idle at random, and the receiver
// holds off long enough once to stall the input side.
// ----------------------------------------------------------------------------
module combination_unrank_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cu_pkg::*;

    localparam int MAX_SET      = MAX_SET_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    localparam int IDLE_PERCENT = 18;

    // Register indexes that the block does not implement; writes to them
    // must leave the configuration alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // One output beat as the block presents it.
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              rank_error;
    } combo_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [RANK_W-1:0]    rank;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ELEM_W-1:0]    element;
    logic                 last;
    logic                 rank_error;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Shadow copy of the two registers, updated at each write edge.
    logic [CFG_W-1:0]     set_size_q;
    logic [CFG_W-1:0]     choose_count_q;

    // Pascal table C(a,b). It runs one row past the block's table so that
    // C(n,k) for the full set size is at hand when ranks are picked.
    int unsigned          pascal [0:MAX_SET][0:MAX_SET];

    // Beats that accepted ranks still owe, oldest first.
    combo_beat_t          pending_values [$];

    int                   mismatch_count;
    bit                   steady;
    logic                 hold_request = 1'b0;
    int                   hold_left = 0;

    combination_unrank_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rank       (rank),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .element    (element),
        .last       (last),
        .rank_error (rank_error),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Unranking model. For each position the candidates are walked upward;
    // the number of combinations that start with a candidate is
    // C(n - v, remaining). The candidate is taken when the rank falls below
    // that count, otherwise the count is subtracted. A bad setting or a rank
    // past C(n,k) yields one flagged beat with element zero instead.
    // ------------------------------------------------------------------------
    function automatic void unrank_into_pending(input logic [RANK_W-1:0] rank_in);
        int unsigned n, k, r, prev, pos, v, rem, c;
        bit          hit;
        combo_beat_t beat;
        combo_beat_t beats [$];
        n    = set_size_q;
        k    = choose_count_q;
        r    = rank_in;
        prev = 0;
        hit  = (n != 0 && n <= MAX_SET && k != 0 && k <= n);
        for (pos = 0; hit && pos < k; pos++)
        begin
            rem = k - pos - 1;
            hit = 1'b0;
            for (v = prev + 1; v + rem <= n; v++)
            begin
                c = (n - v < MAX_SET && rem < MAX_SET) ? pascal[n - v][rem] : 0;
                if (r < c)
                begin
                    hit = 1'b1;
                    break;
                end
                r -= c;
            end
            if (hit)
            begin
                beat.element    = v[ELEM_W-1:0];
                beat.last       = (pos + 1 == k);
                beat.rank_error = 1'b0;
                beats.push_back(beat);
                prev = v;
            end
        end
        if (!hit)
        begin
            beat.element    = '0;
            beat.last       = 1'b1;
            beat.rank_error = 1'b1;
            pending_values.push_back(beat);
        end
        else
        begin
            foreach (beats[i])
                pending_values.push_back(beats[i]);
        end
    endfunction

    // Mostly ranks inside the valid range, with the boundary on both sides
    // and some full-width noise that lands beyond it.
    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned total, roll;
        roll = $urandom_range(0, 99);
        if (set_size_q == 0 || set_size_q > MAX_SET || choose_count_q == 0 ||
            choose_count_q > set_size_q || roll >= 92)
            return $urandom;
        total = pascal[set_size_q][choose_count_q];
        if (roll < 84)
            return $urandom_range(total - 1, 0);
        if (roll < 88)
            return total - 1;
        return total;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. A beat is offered at a clock edge and held until the edge at
    // which in_stall is low; valid stays up into the next item when there is
    // no gap, so it is never lowered and raised within one step.
    // ------------------------------------------------------------------------
    task automatic send_rank(input logic [RANK_W-1:0] value);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rank     <= value;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        unrank_into_pending(value);
    endtask

    // Stop offering and wait until every owed beat has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_SET_SIZE:     set_size_q     = value;
            REG_CHOOSE_COUNT: choose_count_q = value;
            default:          ;
        endcase
    endtask

    // Registers are only rewritten once the block has gone idle.
    task automatic settle_and_set(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k,
                                  input bit touch_spare);
        wait_for_drain();
        write_reg(REG_SET_SIZE, n);
        write_reg(REG_CHOOSE_COUNT, k);
        if (touch_spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Stalls at random unless a steady stretch is running. A hold
    // request makes it stall for a long run of cycles, counted here.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Each accepted beat is matched against the oldest owed beat.
    always @(posedge clk)
    begin : check_beats
        combo_beat_t got;
        combo_beat_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {element, last, rank_error};
            if (pending_values.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: element=%0d last=%0b rank_error=%0b",
                             got.element, got.last, got.rank_error);
            end
            else
            begin
                want = pending_values.pop_front();
                if (got.element !== want.element || got.last !== want.last ||
                    got.rank_error !== want.rank_error)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("beat mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.element, want.last, want.rank_error,
                                 got.element, got.last, got.rank_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Values straight out of reset: one of 32, so each rank names one value.
    task automatic test_reset_setting();
        send_rank(32'd0);
        send_rank(32'd31);
        send_rank(32'd32);
        send_rank('1);
    endtask

    // Largest counts, the full choice, the one-value set, and both sides of
    // the range boundary.
    task automatic test_extremes();
        settle_and_set(6'd32, 6'd16, 1'b0);
        send_rank(32'd0);
        send_rank(pascal[32][16] - 1);
        send_rank(pascal[32][16]);
        send_rank(32'hAAAA_AAAA);
        send_rank(32'h5555_5555);
        settle_and_set(6'd32, 6'd32, 1'b0);
        send_rank(32'd0);
        send_rank(32'd1);
        settle_and_set(6'd1, 6'd1, 1'b0);
        send_rank(32'd0);
        send_rank(32'd1);
        settle_and_set(6'd32, 6'd31, 1'b0);
        send_rank(pascal[32][31] - 1);
    endtask

    // Settings that can name no combination: more chosen than available, an
    // empty choice, an empty set, a set beyond the table; then a valid 31 of 31.
    task automatic test_bad_settings();
        settle_and_set(6'd5, 6'd6, 1'b0);
        send_rank(32'd0);
        settle_and_set(6'd7, 6'd0, 1'b0);
        send_rank(32'd0);
        settle_and_set(6'd0, 6'd1, 1'b0);
        send_rank(32'd0);
        settle_and_set(6'd33, 6'd3, 1'b0);
        send_rank(32'd0);
        settle_and_set(6'd63, 6'd63, 1'b0);
        send_rank(32'd0);
        settle_and_set(6'd31, 6'd31, 1'b0);
        send_rank(32'd0);
    endtask

    // Writes to the unused indexes must not disturb six choose three.
    task automatic test_unknown_register();
        wait_for_drain();
        write_reg(REG_SET_SIZE, 6'd6);
        write_reg(REG_CHOOSE_COUNT, 6'd3);
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        cfg_we <= 1'b0;
        send_rank(32'd0);
        send_rank(32'd19);
        send_rank(32'd20);
    endtask

    // The receiver stops for a long stretch while ranks keep coming, so the
    // output backs up into the sequencer and then the input.
    task automatic test_backpressure();
        settle_and_set(6'd32, 6'd8, 1'b0);
        hold_request <= 1'b1;
        for (int i = 0; i < 20; i++)
            send_rank(pick_rank());
    endtask

    // Back-to-back ranks with no idling on either side.
    task automatic test_steady_stream();
        settle_and_set(6'd20, 6'd5, 1'b0);
        steady = 1'b1;
        for (int i = 0; i < 30; i++)
            send_rank(pick_rank());
        steady = 1'b0;
    endtask

    // Random settings per phase: mostly valid, some at the full set size,
    // a few that can only give the error beat.
    task automatic test_random_settings();
        int unsigned n, k, roll;
        for (int phase = 0; phase < 11; phase++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(1, MAX_SET - 1);
                        k = $urandom_range(n + 1, 63);
                    end
                    1:
                    begin
                        n = $urandom_range(1, MAX_SET);
                        k = 0;
                    end
                    2:
                    begin
                        n = 0;
                        k = $urandom_range(0, 63);
                    end
                    default:
                    begin
                        n = $urandom_range(MAX_SET + 1, 63);
                        k = $urandom_range(1, 63);
                    end
                endcase
            end
            else if (roll < 30)
            begin
                n = MAX_SET;
                k = $urandom_range(1, MAX_SET);
            end
            else
            begin
                n = $urandom_range(1, MAX_SET);
                k = $urandom_range(1, n);
            end
            settle_and_set(CFG_W'(n), CFG_W'(k), $urandom_range(0, 4) == 0);
            for (int i = 0; i < 32; i++)
                send_rank(pick_rank());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int a = 0; a <= MAX_SET; a++)
            for (int b = 0; b <= MAX_SET; b++)
                pascal[a][b] = (b == 0) ? 1 :
                               (a == 0) ? 0 : pascal[a - 1][b] + pascal[a - 1][b - 1];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rank           = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SET_SIZE;
        cfg_data       = '0;
        set_size_q     = SET_SIZE_RST;
        choose_count_q = CHOOSE_COUNT_RST;
        mismatch_count = 0;
        steady         = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The block builds its table first and keeps in_stall high; the
        // sender simply waits for it.
        test_reset_setting();
        test_extremes();
        test_bad_settings();
        test_unknown_register();
        test_backpressure();
        test_steady_stream();
        test_random_settings();

        // Wait for every owed beat, then watch a while for strays.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_values.size() == 0)
            $display("** combination_unrank_top: PASSED **");
        else
            $display("** combination_unrank_top: FAILED **");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("** combination_unrank_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/cu_pkg.sv
rtl/core/combination_unrank_top.sv
dv/combination_unrank_top_tb.sv
